@@ src/bdbq_pkg.sv @@
// bdbq_pkg: opcodes, direction steps, field widths and defaults for the
// blocked-direction box query block. No dependencies.
`default_nettype none

package bdbq_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int COORD_BITS_DEF  = 16;
    localparam int DIM_BITS        = 8;
    localparam int MASK_BITS       = 4;
    localparam int COUNT_OUT_BITS  = 7;
    localparam int NUM_DIRS        = 4;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // 0 up, 1 right, 2 down, 3 left
    localparam logic signed [1:0] STEP_DX [NUM_DIRS] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1};
    localparam logic signed [1:0] STEP_DY [NUM_DIRS] = '{-2'sd1, 2'sd0, 2'sd1, 2'sd0};

    localparam logic [MASK_BITS-1:0] MASK_ALL_FREE = {MASK_BITS{1'b1}};

    typedef struct packed {
        logic [COUNT_OUT_BITS-1:0] entry_count;
        logic                      table_full;
        logic [MASK_BITS-1:0]      free_mask;
    } result_t;

endpackage

`default_nettype wire

@@ src/bdbq_ram.sv @@
// bdbq_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
`default_nettype none

module bdbq_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ src/blocked_direction_box_query.sv @@
// blocked_direction_box_query: box table with clear, append and four-way
// blocked-direction query. Depends on bdbq_pkg and bdbq_ram.
//
// channel  dir  tdata (low bit up)                      tuser   tlast
// s_axis   in   item_x, item_y, item_width, item_height  opcode  -
// m_axis   out  free_mask, table_full, entry_count       -       -
//
// Clear, append, unused opcodes and a query of an empty table are answered from the
// idle state; any other query scans the table, one stored box per cycle from the RAM.
// rst_n clears the count and handshake state; the table RAM holds no reset.
// A result held by m_tready low does not stop the next transfer in; a second
// finished result waits in a hold slot, and s_tready drops until it drains.
`default_nettype none

module blocked_direction_box_query
    import bdbq_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // item_x, item_y, item_width, item_height, zero pad
    input  wire logic [((2*COORD_BITS+2*DIM_BITS+7)/8)*8-1:0] s_tdata,
    // opcode
    input  wire logic [1:0] s_tuser,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // free_mask, table_full, entry_count, zero pad
    output logic [15:0] m_tdata
);

    localparam int ENTRY_W = 2*COORD_BITS + 2*DIM_BITS;
    localparam int ADDR_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int EW      = COORD_BITS + DIM_BITS + 2;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    localparam logic [CNT_W-1:0]    CNT_MAX = CNT_W'(MAX_ENTRIES);
    localparam logic [CNT_W-1:0]    CNT_ONE = CNT_W'(1);
    localparam logic signed [EW-1:0] E_ONE  = EW'(1);

    logic state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic chk_valid_reg, chk_valid_next;
    logic chk_last_reg, chk_last_next;
    logic [MASK_BITS-1:0] mask_reg, mask_next;
    logic signed [COORD_BITS-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic [DIM_BITS-1:0] qw_reg, qw_next, qh_reg, qh_next;
    logic out_valid_reg, out_valid_next, hold_valid_reg, hold_valid_next;
    result_t out_data_reg, out_data_next, hold_data_reg, hold_data_next;

    logic s_fire;
    logic [1:0] op;
    logic signed [COORD_BITS-1:0] in_x, in_y;
    logic [DIM_BITS-1:0] in_w, in_h;

    logic ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    logic res_valid;
    result_t res_data;
    logic [MASK_BITS-1:0] hit;

    assign op   = s_tuser;
    assign in_x = s_tdata[COORD_BITS-1:0];
    assign in_y = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_w = s_tdata[2*COORD_BITS+DIM_BITS-1:2*COORD_BITS];
    assign in_h = s_tdata[ENTRY_W-1:2*COORD_BITS+DIM_BITS];

    assign s_tready = (state_reg == ST_IDLE) && !hold_valid_reg;
    assign s_fire   = s_tvalid && s_tready;

    // appends and scans never overlap, so the RAM needs no forwarding
    bdbq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES),
        .ADDR_W(ADDR_W)
    ) u_table (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (ram_re),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    // overlap of the shifted query box with the box read back
    always_comb
    begin
        logic signed [COORD_BITS-1:0] bx, by;
        logic [DIM_BITS-1:0] bw, bh;
        logic signed [EW-1:0] b_l, b_r, b_t, b_b, q_l, q_r, q_t, q_b;
        logic signed [EW-1:0] a_l, a_r, a_t, a_b, dx, dy;
        logic skip;
        bx  = ram_rdata[COORD_BITS-1:0];
        by  = ram_rdata[2*COORD_BITS-1:COORD_BITS];
        bw  = ram_rdata[2*COORD_BITS+DIM_BITS-1:2*COORD_BITS];
        bh  = ram_rdata[ENTRY_W-1:2*COORD_BITS+DIM_BITS];
        b_l = EW'(bx);
        b_b = EW'(by);
        b_r = b_l + signed'(EW'(bw)) - E_ONE;
        b_t = b_b - signed'(EW'(bh)) + E_ONE;
        q_l = EW'(qx_reg);
        q_b = EW'(qy_reg);
        q_r = q_l + signed'(EW'(qw_reg)) - E_ONE;
        q_t = q_b - signed'(EW'(qh_reg)) + E_ONE;
        skip = (bx == qx_reg && by == qy_reg) || bw == '0 || bh == '0
               || qw_reg == '0 || qh_reg == '0;
        for (int d = 0; d < NUM_DIRS; d++)
        begin
            dx  = EW'(STEP_DX[d]);
            dy  = EW'(STEP_DY[d]);
            a_l = q_l + dx;
            a_r = q_r + dx;
            a_t = q_t + dy;
            a_b = q_b + dy;
            hit[d] = !skip && !(a_r < b_l || b_r < a_l || a_b < b_t || b_b < a_t);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        chk_valid_next = 1'b0;
        chk_last_next  = 1'b0;
        mask_next      = mask_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        qw_next        = qw_reg;
        qh_next        = qh_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[ADDR_W-1:0];
        ram_wdata      = {in_h, in_w, in_y, in_x};
        ram_re         = 1'b0;
        ram_raddr      = idx_reg[ADDR_W-1:0];
        res_valid      = 1'b0;
        res_data.free_mask   = MASK_ALL_FREE;
        res_data.table_full  = 1'b0;
        res_data.entry_count = COUNT_OUT_BITS'(cnt_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    case (op)
                        OP_CLEAR:
                        begin
                            cnt_next  = '0;
                            res_valid = 1'b1;
                            res_data.entry_count = '0;
                        end
                        OP_APPEND:
                        begin
                            res_valid = 1'b1;
                            if (cnt_reg == CNT_MAX)
                            begin
                                res_data.table_full = 1'b1;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                cnt_next = CNT_W'(cnt_reg + CNT_ONE);
                                res_data.entry_count = COUNT_OUT_BITS'(cnt_next);
                            end
                        end
                        OP_QUERY:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_valid = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                                idx_next   = '0;
                                mask_next  = MASK_ALL_FREE;
                                qx_next    = in_x;
                                qy_next    = in_y;
                                qw_next    = in_w;
                                qh_next    = in_h;
                            end
                        end
                        default:
                        begin
                            res_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (idx_reg < cnt_reg)
                begin
                    ram_re         = 1'b1;
                    idx_next       = CNT_W'(idx_reg + CNT_ONE);
                    chk_valid_next = 1'b1;
                    chk_last_next  = (idx_next == cnt_reg);
                end
                if (chk_valid_reg)
                begin
                    mask_next = mask_reg & ~hit;
                    if (chk_last_reg)
                    begin
                        state_next = ST_IDLE;
                        res_valid  = 1'b1;
                        res_data.free_mask = mask_next;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register plus hold slot
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;
        if (!out_valid_reg || m_tready)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = hold_data_reg;
                hold_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_data_next  = res_data;
            end
        end
        else if (res_valid)
        begin
            hold_valid_next = 1'b1;
            hold_data_next  = res_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            chk_valid_reg  <= 1'b0;
            chk_last_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            chk_valid_reg  <= chk_valid_next;
            chk_last_reg   <= chk_last_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg      <= mask_next;
        qx_reg        <= qx_next;
        qy_reg        <= qy_next;
        qw_reg        <= qw_next;
        qh_reg        <= qh_next;
        out_data_reg  <= out_data_next;
        hold_data_reg <= hold_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg.entry_count, out_data_reg.table_full,
                       out_data_reg.free_mask};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("box count above table depth");

    a_check_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> state_reg == ST_SCAN)
        else $error("table read back outside a scan");

    a_hold_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> out_valid_reg)
        else $error("hold slot filled with output register empty");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire && op == OP_CLEAR |=> cnt_reg == '0)
        else $error("clear did not empty the table");

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// tb: self-checking bench for blocked_direction_box_query. Streams clear, append,
// query and unused-opcode items, predicts each result and checks every output transfer
// in order. Depends on bdbq_pkg and blocked_direction_box_query.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bdbq_pkg::*;

    localparam int MAX_BOXES      = MAX_ENTRIES_DEF;
    localparam int ITEM_TARGET    = 1850;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 2 * MAX_BOXES + 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // item_x, item_y, item_width, item_height
    logic [47:0] s_tdata;
    // opcode
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // free_mask, table_full, entry_count, zero pad
    logic [15:0] m_tdata;

    blocked_direction_box_query #(
        .MAX_ENTRIES (MAX_BOXES),
        .COORD_BITS  (COORD_BITS_DEF)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predicted table contents
    logic signed [15:0] stored_x [MAX_BOXES];
    logic signed [15:0] stored_y [MAX_BOXES];
    logic [7:0]         stored_w [MAX_BOXES];
    logic [7:0]         stored_h [MAX_BOXES];
    int                 stored_count;

    result_t pending_q [$];
    bit      failed;
    bit      steady;
    int      items_sent;
    int      quiet_cycles;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(0, 99) >= 33);
    end

    function automatic result_t predict_result(input logic [1:0] op, input logic [15:0] x,
                                               input logic [15:0] y, input logic [7:0] w,
                                               input logic [7:0] h);
        result_t r;
        longint  qx, qy, qw, qh, sx, sy, bl, br, bt, bb, dx, dy;
        r.free_mask  = MASK_ALL_FREE;
        r.table_full = 1'b0;
        qx = $signed(x);
        qy = $signed(y);
        qw = w;
        qh = h;
        case (op)
            OP_CLEAR: stored_count = 0;
            OP_APPEND:
            begin
                if (stored_count >= MAX_BOXES)
                begin
                    r.table_full = 1'b1;
                end
                else
                begin
                    stored_x[stored_count] = x;
                    stored_y[stored_count] = y;
                    stored_w[stored_count] = w;
                    stored_h[stored_count] = h;
                    stored_count++;
                end
            end
            OP_QUERY:
            begin
                for (int i = 0; i < stored_count; i++)
                begin
                    bl = stored_x[i];
                    bb = stored_y[i];
                    br = bl + longint'(stored_w[i]) - 1;
                    bt = bb - longint'(stored_h[i]) + 1;
                    // boxes sharing the query anchor never block
                    if (!(bl == qx && bb == qy) && qw != 0 && qh != 0
                        && stored_w[i] != 0 && stored_h[i] != 0)
                    begin
                        for (int d = 0; d < NUM_DIRS; d++)
                        begin
                            dx = STEP_DX[d];
                            dy = STEP_DY[d];
                            sx = qx + dx;
                            sy = qy + dy;
                            if (!(sx + qw - 1 < bl || br < sx || sy < bt || bb < sy - qh + 1))
                                r.free_mask[d] = 1'b0;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.entry_count = stored_count[COUNT_OUT_BITS-1:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, quiet_cycles);
            $display("tb: FAIL");
            $finish;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[11:0]);
            if (pending_q.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $time, m_tdata);
                failed = 1'b1;
            end
            else
            begin
                want = pending_q.pop_front();
                if (got.free_mask !== want.free_mask)
                begin
                    $display("%0t free_mask: expected %h actual %h",
                             $time, want.free_mask, got.free_mask);
                    failed = 1'b1;
                end
                if (got.table_full !== want.table_full)
                begin
                    $display("%0t table_full: expected %b actual %b",
                             $time, want.table_full, got.table_full);
                    failed = 1'b1;
                end
                if (got.entry_count !== want.entry_count)
                begin
                    $display("%0t entry_count: expected %0d actual %0d",
                             $time, want.entry_count, got.entry_count);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [15:0] x, input logic [15:0] y,
                             input logic [7:0] w, input logic [7:0] h);
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {h, w, y, x};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_q = {pending_q, predict_result(op, x, y, w, h)};
        items_sent++;
    endtask

    task automatic send_noise();
        send_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                  8'($urandom), 8'($urandom));
    endtask

    // hold off the sender until every outstanding result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_centre();
        case ($urandom_range(0, 5))
            0:       return 16'h8000 + 16'($urandom_range(0, 8));
            1:       return 16'h7FFF - 16'($urandom_range(0, 8));
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 400)) - 16'd200;
        endcase
    endfunction

    function automatic logic [7:0] pick_dim();
        case ($urandom_range(0, 19))
            0:       return 8'd0;
            1:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [15:0] jitter(input logic [15:0] c);
        return c + 16'($urandom_range(0, 12)) - 16'd6;
    endfunction

    task automatic test_basic_ops();
        send_item(OP_QUERY,  16'd0, 16'd0, 8'd1, 8'd1);
        send_item(OP_APPEND, 16'd0, 16'd0, 8'd2, 8'd2);
        send_item(OP_QUERY,  16'd2, 16'd0, 8'd1, 8'd1);
        send_item(OP_QUERY,  16'd0, 16'd1, 8'd1, 8'd1);
        send_item(OP_QUERY,  16'd0, 16'd0, 8'd3, 8'd3);
        send_item(OP_APPEND, 16'd5, 16'd5, 8'd0, 8'd3);
        send_item(OP_APPEND, 16'd9, 16'd5, 8'd3, 8'd0);
        send_item(OP_QUERY,  16'd5, 16'd6, 8'd1, 8'd1);
        send_item(OP_QUERY,  16'd9, 16'd6, 8'd1, 8'd1);
        send_item(OP_QUERY,  16'd0, 16'd1, 8'd0, 8'd1);
        send_item(OP_QUERY,  16'hFFFF, 16'd0, 8'd1, 8'd0);
        send_item(OP_UNUSED, 16'h5555, 16'hAAAA, 8'h55, 8'hAA);
        send_item(OP_CLEAR,  16'hAAAA, 16'h5555, 8'hAA, 8'h55);
        send_item(OP_QUERY,  16'd2, 16'd0, 8'd1, 8'd1);
    endtask

    task automatic test_coordinate_limits();
        send_item(OP_APPEND, 16'h8000, 16'h7FFF, 8'd255, 8'd255);
        send_item(OP_APPEND, 16'h7FFF, 16'h8000, 8'd255, 8'd255);
        send_item(OP_QUERY,  16'h7FFF, 16'h7FFF, 8'd1, 8'd1);
        send_item(OP_QUERY,  16'h8000, 16'h8000, 8'd255, 8'd255);
        send_item(OP_QUERY,  16'h8001, 16'h7FFF, 8'd1, 8'd1);
        send_item(OP_QUERY,  16'h8000, 16'h7FFF, 8'd3, 8'd3);
        send_item(OP_QUERY,  16'h7FFE, 16'h8100, 8'd255, 8'd1);
        send_item(OP_CLEAR,  16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_full_table();
        logic [15:0] cx, cy;
        cx = 16'd100;
        cy = 16'hFF00;
        send_item(OP_CLEAR, 16'd0, 16'd0, 8'd0, 8'd0);
        repeat (MAX_BOXES) send_item(OP_APPEND, jitter(cx), jitter(cy), pick_dim(), pick_dim());
        send_item(OP_APPEND, cx, cy, 8'd1, 8'd1);
        send_item(OP_APPEND, 16'h7FFF, 16'h8000, 8'd255, 8'd255);
        send_item(OP_UNUSED, cx, cy, 8'd1, 8'd1);
        repeat (3) send_item(OP_QUERY, jitter(cx), jitter(cy), pick_dim(), pick_dim());
        send_item(OP_QUERY, stored_x[0], stored_y[0], 8'd2, 8'd2);
        wait_for_results();
        send_item(OP_CLEAR, 16'd0, 16'd0, 8'd0, 8'd0);
    endtask

    task automatic test_random();
        logic [15:0] cx, cy;
        int          n_boxes, k;
        while (items_sent < ITEM_TARGET)
        begin
            steady = (items_sent >= 500 && items_sent < 850);
            if ($urandom_range(0, 9) < 8)
            begin
                cx = pick_centre();
                cy = pick_centre();
                if ($urandom_range(0, 3) != 0)
                    send_item(OP_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
                n_boxes = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 70)
                                                       : $urandom_range(1, 10);
                repeat (n_boxes)
                    send_item(OP_APPEND, jitter(cx), jitter(cy), pick_dim(), pick_dim());
                repeat ($urandom_range(1, 10))
                begin
                    k = $urandom_range(0, 9);
                    if (k == 0)
                        send_noise();
                    else if (k < 3 && stored_count > 0)
                    begin
                        k = $urandom_range(0, stored_count - 1);
                        send_item(OP_QUERY, stored_x[k], stored_y[k], pick_dim(), pick_dim());
                    end
                    else
                        send_item(OP_QUERY, jitter(cx), jitter(cy), pick_dim(), pick_dim());
                end
            end
            else
            begin
                repeat ($urandom_range(5, 20)) send_noise();
            end
            if ($urandom_range(0, 7) == 0)
                wait_for_results();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        failed       = 1'b0;
        steady       = 1'b0;
        items_sent   = 0;
        quiet_cycles = 0;
        stored_count = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_CLEAR;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_coordinate_limits();
        test_full_table();
        test_random();

        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
